// ----- rtl/core/ctf_pkg.sv -----
`default_nettype none

package ctf_pkg;

    // Register indexes on the configuration port
    localparam int CFG_IDX_W = 3;
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROLL_WEIGHT   = 3'd0,
        REG_PITCH_WEIGHT  = 3'd1,
        REG_GYRO_OFFSET_X = 3'd2,
        REG_GYRO_OFFSET_Y = 3'd3
    } ctf_reg_t;

    localparam logic [15:0] WEIGHT_RESET = 16'd52429;

    // One input word, accel_x in the lowest bits and elapsed_us in the highest
    typedef struct packed {
        logic [19:0]        elapsed_us;
        logic signed [15:0] gyro_y;
        logic signed [15:0] gyro_x;
        logic signed [15:0] accel_z;
        logic signed [15:0] accel_y;
        logic signed [15:0] accel_x;
    } ctf_item_t;

    localparam int ITEM_W  = $bits(ctf_item_t);
    localparam int IN_TD_W = ((ITEM_W + 7) / 8) * 8;

    // One result word, roll_angle in the lowest bits and accel_pitch in the highest
    typedef struct packed {
        logic signed [15:0] accel_pitch;
        logic signed [15:0] accel_roll;
        logic signed [15:0] pitch_angle;
        logic signed [15:0] roll_angle;
    } ctf_result_t;

    typedef struct packed {
        logic [15:0]        roll_weight;
        logic [15:0]        pitch_weight;
        logic signed [15:0] gyro_offset_x;
        logic signed [15:0] gyro_offset_y;
    } ctf_cfg_t;

    localparam int MAX_STEPS = 24;

    // Arctangent of 2^-i in radians, Q30, truncated
    function automatic logic [29:0] ctf_atan(input logic [4:0] idx);
        logic [29:0] v;
        case (idx)
            5'd0:    v = 30'd843314856;
            5'd1:    v = 30'd497837829;
            5'd2:    v = 30'd263043836;
            5'd3:    v = 30'd133525158;
            5'd4:    v = 30'd67021686;
            5'd5:    v = 30'd33543515;
            5'd6:    v = 30'd16775850;
            5'd7:    v = 30'd8388437;
            5'd8:    v = 30'd4194282;
            5'd9:    v = 30'd2097149;
            5'd10:   v = 30'd1048575;
            5'd11:   v = 30'd524287;
            5'd12:   v = 30'd262143;
            5'd13:   v = 30'd131071;
            5'd14:   v = 30'd65535;
            5'd15:   v = 30'd32767;
            5'd16:   v = 30'd16383;
            5'd17:   v = 30'd8191;
            5'd18:   v = 30'd4095;
            5'd19:   v = 30'd2047;
            5'd20:   v = 30'd1023;
            5'd21:   v = 30'd511;
            5'd22:   v = 30'd255;
            5'd23:   v = 30'd127;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/ctf_queue.sv -----
`default_nettype none

// Two-word queue between the input side and the compute engine
module ctf_queue
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire ctf_pkg::ctf_item_t    in_item,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output ctf_pkg::ctf_item_t         out_item
);
    import ctf_pkg::*;

    ctf_item_t  slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push, pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_item  = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    // Advance pointers and fill count
    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the incoming word
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/ctf_engine.sv -----
`default_nettype none

// Sequencer: two CORDIC atan2 runs, then two filter updates that each divide
// by 31250 with a split reciprocal multiply, then hand off one result word.
module ctf_engine
#(
    parameter int CORDIC_STEPS = 16
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire ctf_pkg::ctf_cfg_t     cfg,
    input  wire logic                  item_valid,
    output logic                       item_ready,
    input  wire ctf_pkg::ctf_item_t    item,
    output logic                       res_valid,
    input  wire logic                  res_take,
    output ctf_pkg::ctf_result_t       res
);
    import ctf_pkg::*;

    localparam int NSTEPS   = (CORDIC_STEPS < MAX_STEPS) ? CORDIC_STEPS : MAX_STEPS;
    localparam int DIV_BITS = 37;

    localparam logic signed [35:0] PI_Q30    = 36'sd3373259426;
    localparam logic [53:0]        HALF_11Q30 = 54'd5905580032;
    localparam logic [19:0]        RECIP_11  = 20'd762601;
    localparam logic [22:0]        RECIP_131 = 23'd8196503;
    // ceil(2^50 / 15625) split at bit 19
    localparam logic [18:0]        RECIP_DT_LO = 19'd499894;
    localparam logic [17:0]        RECIP_DT_HI = 18'd137438;
    localparam logic [16:0]        ANGLE_MAX = 17'd23040;

    typedef enum logic [4:0] {
        S_IDLE, S_CINIT, S_CITER, S_CSCALE, S_CROUND, S_CDONE,
        S_RATE, S_RATE2, S_DIVI, S_DIV, S_DIV2, S_DIV3, S_SUM, S_MIX1, S_MIX2, S_MIX3,
        S_OUT
    } state_t;

    state_t state_reg, state_next;
    logic [5:0] cnt_reg, cnt_next;
    logic axis_reg, axis_next;
    logic zero_reg, zero_next;
    logic neg_reg, neg_next;
    logic signed [23:0] st_roll_reg, st_roll_next;
    logic signed [23:0] st_pitch_reg, st_pitch_next;

    ctf_item_t item_reg, item_next;
    logic signed [36:0] cx_reg, cx_next, cy_reg, cy_next;
    logic signed [35:0] z_reg, z_next;
    logic signed [53:0] scl_reg, scl_next;
    logic [39:0] tmul_reg, tmul_next;
    logic signed [15:0] a_roll_reg, a_roll_next, a_pitch_reg, a_pitch_next;
    logic [45:0] rmul_reg, rmul_next;
    logic signed [38:0] pr2_reg, pr2_next;
    logic [36:0] num_reg, num_next;
    logic [54:0] plo_reg, plo_next;
    logic [53:0] phi_reg, phi_next;
    logic [21:0] quo_reg, quo_next;
    logic signed [25:0] sum_reg, sum_next;
    logic signed [42:0] p1_reg, p1_next;
    logic signed [38:0] p2_reg, p2_next;
    logic signed [43:0] mix_reg, mix_next;

    // Working values
    logic signed [15:0] op_y, op_x, gyro, ang_acc, offset;
    logic signed [36:0] sh_x, sh_y, init_x, init_y;
    logic [53:0] scl_mag, scl_rnd;
    logic [16:0] q_ang, g_mag;
    logic signed [16:0] ang_s;
    logic [23:0] g_t;
    logic signed [17:0] rate;
    logic [38:0] pr2_mag;
    logic [54:0] dsum;
    logic signed [22:0] delta;
    logic signed [23:0] prev;
    logic [15:0] weight;
    logic [16:0] wc;
    logic [43:0] mix_mag, mix_rnd;
    logic [27:0] mix_q;
    logic signed [23:0] st_new;
    logic signed [15:0] r_out, p_out;

    assign item_ready = (state_reg == S_IDLE);
    assign res_valid  = (state_reg == S_OUT);

    // Round one state value to 1/128 degree and saturate to 16 bits
    function automatic logic signed [15:0] out_round(input logic signed [23:0] st);
        logic [23:0] m;
        logic [18:0] q;
        logic signed [15:0] o;
        m = st[23] ? 24'(-st) : 24'(st);
        q = 19'((25'(m) + 25'd16) >> 5);
        if (!st[23])
        begin
            o = (q > 19'd32767) ? 16'sd32767 : $signed(16'(q));
        end
        else
        begin
            o = (q > 19'd32768) ? -16'sd32768 : $signed(16'(-q));
        end
        return o;
    endfunction

    always_comb
    begin
        op_y    = axis_reg ? item_reg.accel_x : item_reg.accel_y;
        op_x    = item_reg.accel_z;
        gyro    = axis_reg ? item_reg.gyro_y : item_reg.gyro_x;
        offset  = axis_reg ? cfg.gyro_offset_y : cfg.gyro_offset_x;
        weight  = axis_reg ? cfg.pitch_weight : cfg.roll_weight;
        ang_acc = axis_reg ? a_pitch_reg : a_roll_reg;
        prev    = axis_reg ? st_pitch_reg : st_roll_reg;
        init_x  = {{5{op_x[15]}}, op_x, 16'd0};
        init_y  = {{5{op_y[15]}}, op_y, 16'd0};
        sh_x    = cx_reg >>> cnt_reg[4:0];
        sh_y    = cy_reg >>> cnt_reg[4:0];
        scl_mag = scl_reg[53] ? 54'(-scl_reg) : 54'(scl_reg);
        scl_rnd = scl_mag + HALF_11Q30;
        q_ang   = tmul_reg[39:23];
        if (q_ang > ANGLE_MAX)
        begin
            q_ang = ANGLE_MAX;
        end
        ang_s   = neg_reg ? $signed(-q_ang) : $signed(q_ang);
        g_mag   = gyro[15] ? 17'(-18'(gyro)) : 17'(gyro);
        g_t     = {g_mag, 7'd0} + 24'd65;
        rate    = (neg_reg ? -$signed({2'b00, rmul_reg[45:30]})
                           : $signed({2'b00, rmul_reg[45:30]})) - 18'(offset);
        pr2_mag = pr2_reg[38] ? 39'(-pr2_reg) : 39'(pr2_reg);
        dsum    = 55'(phi_reg) + 55'(plo_reg[54:19]);
        delta   = neg_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});
        wc      = 17'(18'd65536 - 18'(weight));
        mix_mag = mix_reg[43] ? 44'(-mix_reg) : 44'(mix_reg);
        mix_rnd = mix_mag + 44'd32768;
        mix_q   = mix_rnd[43:16];
        if (!mix_reg[43])
        begin
            st_new = (mix_q > 28'd8388607) ? 24'sh7FFFFF : $signed(24'(mix_q));
        end
        else
        begin
            st_new = (mix_q > 28'd8388608) ? 24'sh800000 : $signed(24'(-mix_q));
        end
        r_out = out_round(st_roll_reg);
        p_out = out_round(st_pitch_reg);
    end

    assign res.roll_angle  = r_out;
    assign res.pitch_angle = p_out;
    assign res.accel_roll  = a_roll_reg;
    assign res.accel_pitch = a_pitch_reg;

    // Sequence one item
    always_comb
    begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        axis_next     = axis_reg;
        zero_next     = zero_reg;
        neg_next      = neg_reg;
        st_roll_next  = st_roll_reg;
        st_pitch_next = st_pitch_reg;
        item_next     = item_reg;
        cx_next       = cx_reg;
        cy_next       = cy_reg;
        z_next        = z_reg;
        scl_next      = scl_reg;
        tmul_next     = tmul_reg;
        a_roll_next   = a_roll_reg;
        a_pitch_next  = a_pitch_reg;
        rmul_next     = rmul_reg;
        pr2_next      = pr2_reg;
        num_next      = num_reg;
        plo_next      = plo_reg;
        phi_next      = phi_reg;
        quo_next      = quo_reg;
        sum_next      = sum_reg;
        p1_next       = p1_reg;
        p2_next       = p2_reg;
        mix_next      = mix_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    item_next  = item;
                    axis_next  = 1'b0;
                    state_next = S_CINIT;
                end
            end
            S_CINIT:
            begin
                // Fold the left half-plane over and start from +/- pi
                zero_next = (op_x == 16'sd0) && (op_y == 16'sd0);
                cnt_next  = 6'd0;
                if (op_x[15])
                begin
                    cx_next = -init_x;
                    cy_next = -init_y;
                    z_next  = op_y[15] ? -PI_Q30 : PI_Q30;
                end
                else
                begin
                    cx_next = init_x;
                    cy_next = init_y;
                    z_next  = 36'sd0;
                end
                state_next = S_CITER;
            end
            S_CITER:
            begin
                if (!cy_reg[36])
                begin
                    cx_next = cx_reg + sh_y;
                    cy_next = cy_reg - sh_x;
                    z_next  = z_reg + $signed({6'd0, ctf_atan(cnt_reg[4:0])});
                end
                else
                begin
                    cx_next = cx_reg - sh_y;
                    cy_next = cy_reg + sh_x;
                    z_next  = z_reg - $signed({6'd0, ctf_atan(cnt_reg[4:0])});
                end
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'(NSTEPS - 1))
                begin
                    state_next = S_CSCALE;
                end
            end
            S_CSCALE:
            begin
                scl_next   = 54'(z_reg) * 54'sd80640;
                state_next = S_CROUND;
            end
            S_CROUND:
            begin
                // Divide by 11 * 2^30 as shift then reciprocal multiply
                neg_next   = scl_reg[53];
                tmul_next  = 40'(scl_rnd[49:30]) * 40'(RECIP_11);
                state_next = S_CDONE;
            end
            S_CDONE:
            begin
                if (!axis_reg)
                begin
                    a_roll_next = zero_reg ? 16'sd0 : 16'(ang_s);
                    axis_next   = 1'b1;
                    state_next  = S_CINIT;
                end
                else
                begin
                    a_pitch_next = zero_reg ? 16'sd0 : 16'(-ang_s);
                    axis_next    = 1'b0;
                    state_next   = S_RATE;
                end
            end
            S_RATE:
            begin
                neg_next   = gyro[15];
                rmul_next  = 46'(g_t) * 46'(RECIP_131);
                state_next = S_RATE2;
            end
            S_RATE2:
            begin
                pr2_next   = 39'(rate) * $signed({19'd0, item_reg.elapsed_us});
                state_next = S_DIVI;
            end
            S_DIVI:
            begin
                neg_next   = pr2_reg[38];
                num_next   = pr2_mag[DIV_BITS-1:0] + 37'd15625;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                // Halve, then multiply by the reciprocal of 15625: low part
                plo_next   = 55'(num_reg[DIV_BITS-1:1]) * 55'(RECIP_DT_LO);
                state_next = S_DIV2;
            end
            S_DIV2:
            begin
                phi_next   = 54'(num_reg[DIV_BITS-1:1]) * 54'(RECIP_DT_HI);
                state_next = S_DIV3;
            end
            S_DIV3:
            begin
                // Combine both parts and drop 50 fraction bits
                quo_next   = dsum[52:31];
                state_next = S_SUM;
            end
            S_SUM:
            begin
                sum_next   = 26'(prev) + 26'(delta);
                state_next = S_MIX1;
            end
            S_MIX1:
            begin
                p1_next    = 43'(sum_reg) * $signed({27'd0, weight});
                p2_next    = 39'($signed({ang_acc, 5'd0})) * $signed({22'd0, wc});
                state_next = S_MIX2;
            end
            S_MIX2:
            begin
                mix_next   = 44'(p1_reg) + 44'(p2_reg);
                state_next = S_MIX3;
            end
            S_MIX3:
            begin
                if (!axis_reg)
                begin
                    st_roll_next = st_new;
                    axis_next    = 1'b1;
                    state_next   = S_RATE;
                end
                else
                begin
                    st_pitch_next = st_new;
                    state_next    = S_OUT;
                end
            end
            S_OUT:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold control state and filter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            cnt_reg      <= 6'd0;
            axis_reg     <= 1'b0;
            zero_reg     <= 1'b0;
            neg_reg      <= 1'b0;
            st_roll_reg  <= 24'sd0;
            st_pitch_reg <= 24'sd0;
        end
        else
        begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            axis_reg     <= axis_next;
            zero_reg     <= zero_next;
            neg_reg      <= neg_next;
            st_roll_reg  <= st_roll_next;
            st_pitch_reg <= st_pitch_next;
        end
    end

    // Hold datapath values
    always_ff @(posedge clk)
    begin
        item_reg    <= item_next;
        cx_reg      <= cx_next;
        cy_reg      <= cy_next;
        z_reg       <= z_next;
        scl_reg     <= scl_next;
        tmul_reg    <= tmul_next;
        a_roll_reg  <= a_roll_next;
        a_pitch_reg <= a_pitch_next;
        rmul_reg    <= rmul_next;
        pr2_reg     <= pr2_next;
        num_reg     <= num_next;
        plo_reg     <= plo_next;
        phi_reg     <= phi_next;
        quo_reg     <= quo_next;
        sum_reg     <= sum_next;
        p1_reg      <= p1_next;
        p2_reg      <= p2_next;
        mix_reg     <= mix_next;
    end

endmodule

`default_nettype wire

// ----- rtl/core/complementary_tilt_filter_unit.sv -----
// Complementary roll/pitch filter. Each input word carries one IMU sample
// (raw accel X/Y/Z, raw gyro X/Y, elapsed microseconds); each produces one
// output word with filtered roll and pitch and the accelerometer-only angles,
// all in 1/128 degree. Input words go into a two-word queue so the source
// can run ahead, and the result sits in an output register so the engine can
// start the next sample while the sink stalls. For each sample the engine
// takes the word, runs two CORDIC atan2 passes (set-up, CORDIC_STEPS
// iterations capped at 24, scaling, rounding), two filter updates (gyro
// rate, a two-part reciprocal divide by 31250, the weighted mix), and hands
// off the result word, waiting only while the output register is full and
// the sink stalls. The user must write weights and gyro offsets through the
// cfg port only while idle; the block itself does not enforce it.
`default_nettype none

module complementary_tilt_filter_unit
#(
    parameter int CORDIC_STEPS = 16
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    // accel_x, accel_y, accel_z, gyro_x, gyro_y, elapsed_us, zero pad
    input  wire logic [103:0]  s_tdata,
    output logic               m_tvalid,
    input  wire logic          m_tready,
    // roll_angle, pitch_angle, accel_roll, accel_pitch
    output logic [63:0]        m_tdata,
    input  wire logic          cfg_we,
    input  wire logic [2:0]    cfg_index,
    input  wire logic [15:0]   cfg_wdata
);
    import ctf_pkg::*;

    ctf_cfg_t    cfg_reg, cfg_next;
    ctf_item_t   q_item;
    logic        q_valid, q_ready;
    logic        res_valid, res_take;
    ctf_result_t res;
    logic        out_valid_reg, out_valid_next;
    ctf_result_t out_reg;

    // Write configuration registers
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (ctf_reg_t'(cfg_index))
                REG_ROLL_WEIGHT:   cfg_next.roll_weight   = cfg_wdata;
                REG_PITCH_WEIGHT:  cfg_next.pitch_weight  = cfg_wdata;
                REG_GYRO_OFFSET_X: cfg_next.gyro_offset_x = $signed(cfg_wdata);
                REG_GYRO_OFFSET_Y: cfg_next.gyro_offset_y = $signed(cfg_wdata);
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.roll_weight   <= WEIGHT_RESET;
            cfg_reg.pitch_weight  <= WEIGHT_RESET;
            cfg_reg.gyro_offset_x <= 16'sd0;
            cfg_reg.gyro_offset_y <= 16'sd0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    ctf_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_item   (ctf_item_t'(s_tdata[ITEM_W-1:0])),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_item  (q_item)
    );

    ctf_engine #(.CORDIC_STEPS(CORDIC_STEPS)) u_engine
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .item_valid (q_valid),
        .item_ready (q_ready),
        .item       (q_item),
        .res_valid  (res_valid),
        .res_take   (res_take),
        .res        (res)
    );

    // Output register: load when empty or being drained
    assign res_take = res_valid && (!out_valid_reg || m_tready);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_take)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

    // A word handed over from the engine shows up at the output next cycle
    a_take_shows: assert property (@(posedge clk) disable iff (!rst_n)
        res_take |=> (m_tvalid && (m_tdata == $past(res))))
        else $error("result word not loaded into output register");

    // Accelerometer angles stay within +/-180 degrees
    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ($signed(m_tdata[47:32]) <= 16'sd23040 &&
                      $signed(m_tdata[47:32]) >= -16'sd23040 &&
                      $signed(m_tdata[63:48]) <= 16'sd23040 &&
                      $signed(m_tdata[63:48]) >= -16'sd23040))
        else $error("accelerometer angle out of range");

    // The engine never takes a new sample while a result waits for hand-off
    a_no_skip: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_take) |=> res_valid)
        else $error("result dropped before hand-off");

endmodule

`default_nettype wire

// ----- tb/sv/tb_complementary_tilt_filter_unit.sv -----
`timescale 1ns / 1ps

module tb_complementary_tilt_filter_unit;
    import ctf_pkg::*;

    localparam int  STEPS       = 16;
    localparam int  LATENCY     = 2 * STEPS + 30;
    localparam longint PI_Q30   = 64'sd3373259426;
    localparam longint CYCLE_LIMIT = 64'd2_000_000;

    logic          clk;
    logic          rst_n;
    logic          s_tvalid;
    logic          s_tready;
    logic [103:0]  s_tdata;
    logic          m_tvalid;
    logic          m_tready;
    logic [63:0]   m_tdata;
    logic          cfg_we;
    logic [2:0]    cfg_index;
    logic [15:0]   cfg_wdata;

    complementary_tilt_filter_unit #(.CORDIC_STEPS(STEPS)) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // Predictor state and register copies
    logic [15:0]        roll_w;
    logic [15:0]        pitch_w;
    logic signed [15:0] offset_x;
    logic signed [15:0] offset_y;
    longint             roll_state;
    longint             pitch_state;

    ctf_result_t expected_results[$];
    int          error_count;
    longint      cycle_count;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          hold_off_cycles;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Bound the run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("complementary_tilt_filter_unit test failed");
            $finish;
        end
    end

    function automatic longint floor_shift(longint v, int s);
        if (v >= 0)
            return v >>> s;
        return -((-v + (64'sd1 <<< s) - 1) >>> s);
    endfunction

    // Round to nearest, ties away from zero
    function automatic longint round_div(longint n, longint d);
        longint m;
        longint q;
        m = (n < 0) ? -n : n;
        q = (m + d / 2) / d;
        return (n < 0) ? -q : q;
    endfunction

    function automatic longint clamp(longint v, longint lo, longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function automatic longint atan_step(int i);
        longint tbl[24] = '{843314856, 497837829, 263043836, 133525158, 67021686,
                            33543515, 16775850, 8388437, 4194282, 2097149, 1048575,
                            524287, 262143, 131071, 65535, 32767, 16383, 8191,
                            4095, 2047, 1023, 511, 255, 127};
        return tbl[i];
    endfunction

    // Vectoring CORDIC atan2(y, x) scaled to 1/128 degree
    function automatic longint tilt_of(longint y, longint x);
        longint cx;
        longint cy;
        longint z;
        longint nx;
        cx = x * 65536;
        cy = y * 65536;
        z  = 0;
        if (x == 0 && y == 0)
            return 0;
        if (cx < 0)
        begin
            cx = -cx;
            cy = -cy;
            z  = (y >= 0) ? PI_Q30 : -PI_Q30;
        end
        for (int i = 0; i < STEPS && i < 24; i++)
        begin
            if (cy >= 0)
            begin
                nx = cx + floor_shift(cy, i);
                cy = cy - floor_shift(cx, i);
                z += atan_step(i);
            end
            else
            begin
                nx = cx - floor_shift(cy, i);
                cy = cy + floor_shift(cx, i);
                z -= atan_step(i);
            end
            cx = nx;
        end
        return clamp(round_div(z * 80640, 64'sd11 <<< 30), -23040, 23040);
    endfunction

    function automatic longint blend_angle(longint prev, longint gyro, longint ofs,
                                           longint dt, longint w, longint acc);
        longint rate;
        longint sum;
        longint mix;
        rate = round_div(gyro * 128, 131) - ofs;
        sum  = prev + round_div(rate * dt, 31250);
        mix  = w * sum + (65536 - w) * 32 * acc;
        return clamp(round_div(mix, 65536), -8388608, 8388607);
    endfunction

    // Advance the filter state and queue the expected result word
    task automatic predict_sample(input ctf_item_t it);
        ctf_result_t r;
        longint      ar;
        longint      ap;
        ar = tilt_of(it.accel_y, it.accel_z);
        ap = -tilt_of(it.accel_x, it.accel_z);
        roll_state  = blend_angle(roll_state, it.gyro_x, offset_x, it.elapsed_us, roll_w, ar);
        pitch_state = blend_angle(pitch_state, it.gyro_y, offset_y, it.elapsed_us,
                                  pitch_w, ap);
        r.roll_angle  = 16'(clamp(round_div(roll_state, 32), -32768, 32767));
        r.pitch_angle = 16'(clamp(round_div(pitch_state, 32), -32768, 32767));
        r.accel_roll  = 16'(ar);
        r.accel_pitch = 16'(ap);
        expected_results.push_back(r);
    endtask

    task automatic report_mismatch(input string what, input logic [15:0] got,
                                   input logic [15:0] want);
        $display("MISMATCH %s: got %0d expected %0d", what, $signed(got), $signed(want));
        error_count++;
    endtask

    // Send one word, idling at random before it
    task automatic send_sample(input ctf_item_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {8'd0, it};
        predict_sample(it);
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // Drive the sink ready
    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_off_cycles > 0)
        begin
            m_tready <= 1'b0;
            hold_off_cycles <= hold_off_cycles - 1;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Check each result word
    always @(posedge clk)
    begin
        ctf_result_t got;
        ctf_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata;
            if (expected_results.size() == 0)
            begin
                report_mismatch("unexpected word, roll_angle", got.roll_angle, 16'd0);
            end
            else
            begin
                want = expected_results.pop_front();
                if (got.roll_angle !== want.roll_angle)
                    report_mismatch("roll_angle", got.roll_angle, want.roll_angle);
                if (got.pitch_angle !== want.pitch_angle)
                    report_mismatch("pitch_angle", got.pitch_angle, want.pitch_angle);
                if (got.accel_roll !== want.accel_roll)
                    report_mismatch("accel_roll", got.accel_roll, want.accel_roll);
                if (got.accel_pitch !== want.accel_pitch)
                    report_mismatch("accel_pitch", got.accel_pitch, want.accel_pitch);
            end
        end
    end

    // Drop valid and wait for every expected word
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 8) @(posedge clk);
    endtask

    // Write one register; the block must be idle
    task automatic write_reg(input ctf_reg_t idx, input logic [15:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_ROLL_WEIGHT:   roll_w   = val;
            REG_PITCH_WEIGHT:  pitch_w  = val;
            REG_GYRO_OFFSET_X: offset_x = val;
            REG_GYRO_OFFSET_Y: offset_y = val;
            default: ;
        endcase
    endtask

    task automatic write_all(input logic [15:0] rw, input logic [15:0] pw,
                             input logic [15:0] ox, input logic [15:0] oy);
        write_reg(REG_ROLL_WEIGHT, rw);
        write_reg(REG_PITCH_WEIGHT, pw);
        write_reg(REG_GYRO_OFFSET_X, ox);
        write_reg(REG_GYRO_OFFSET_Y, oy);
    endtask

    function automatic ctf_item_t make_sample(int ax, int ay, int az, int gx, int gy,
                                              int dt);
        ctf_item_t it;
        it.accel_x    = 16'(ax);
        it.accel_y    = 16'(ay);
        it.accel_z    = 16'(az);
        it.gyro_x     = 16'(gx);
        it.gyro_y     = 16'(gy);
        it.elapsed_us = 20'(dt);
        return it;
    endfunction

    // Mostly plausible tilt samples, some raw noise
    function automatic ctf_item_t random_sample();
        ctf_item_t it;
        it = make_sample($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        if ($urandom_range(99) < 70)
        begin
            it.accel_x    = 16'($signed($urandom_range(16384)) - 8192);
            it.accel_y    = 16'($signed($urandom_range(16384)) - 8192);
            it.accel_z    = 16'($signed($urandom_range(20000)) - 4000);
            it.gyro_x     = 16'($signed($urandom_range(8000)) - 4000);
            it.gyro_y     = 16'($signed($urandom_range(8000)) - 4000);
            it.elapsed_us = 20'($urandom_range(500, 20000));
        end
        return it;
    endfunction

    task automatic test_directed();
        send_sample(make_sample(0, 0, 0, 0, 0, 0));
        send_sample(make_sample(0, 0, 16384, 0, 0, 1000));
        send_sample(make_sample(5000, 5000, -16384, 131, -131, 1000));
        send_sample(make_sample(-5000, -5000, -16384, 0, 0, 1000));
        send_sample(make_sample(100, 0, -100, 0, 0, 1000));
        send_sample(make_sample(-100, 0, -100, 0, 0, 1000));
        send_sample(make_sample(0, 16384, 0, 0, 0, 1000));
        send_sample(make_sample(16384, -16384, 0, 0, 0, 1000));
        send_sample(make_sample(32767, 32767, 32767, 32767, 32767, 1048575));
        send_sample(make_sample(-32768, -32768, -32768, -32768, -32768, 1048575));
        send_sample(make_sample(32767, -32768, 1, 32767, 32767, 1048575));
        send_sample(make_sample(-32768, 32767, -1, -32768, -32768, 1048575));
        send_sample(make_sample(0, 0, -32768, 0, 0, 0));
        send_sample(make_sample(1, -1, 0, 65, -66, 1));
        send_sample(make_sample(-1, 1, 32767, 0, 0, 0));
        wait_drained();
    endtask

    task automatic test_config_extremes();
        write_all(16'd0, 16'd65535, 16'h7fff, 16'h8000);
        repeat (8) send_sample(random_sample());
        send_sample(make_sample(0, 0, 16384, 32767, -32768, 1048575));
        wait_drained();
        write_all(16'd65535, 16'd0, 16'h8000, 16'h7fff);
        repeat (8) send_sample(random_sample());
        send_sample(make_sample(0, 0, 16384, -32768, 32767, 1048575));
        wait_drained();
        write_all(16'd32768, 16'd1, 16'd0, 16'hffff);
        repeat (6) send_sample(random_sample());
        wait_drained();
    endtask

    task automatic test_random(input int count, input int s_idle, input int r_idle);
        send_idle_pct = s_idle;
        recv_idle_pct = r_idle;
        write_all(16'($urandom), 16'($urandom), 16'($signed($urandom_range(2000)) - 1000),
                  16'($signed($urandom_range(2000)) - 1000));
        repeat (count) send_sample(random_sample());
        wait_drained();
    endtask

    // Stall the sink long enough that the input queue fills up
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_off_cycles = 2000;
        repeat (10) send_sample(random_sample());
        wait_drained();
    endtask

    initial
    begin
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        m_tready  = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = REG_ROLL_WEIGHT;
        cfg_wdata = '0;
        error_count = 0;
        cycle_count = 0;
        hold_off_cycles = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        roll_w   = WEIGHT_RESET;
        pitch_w  = WEIGHT_RESET;
        offset_x = '0;
        offset_y = '0;
        roll_state  = 0;
        pitch_state = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_config_extremes();
        test_backpressure();
        test_random(260, 11, 71);
        test_random(260, 71, 11);
        test_random(260, 0, 0);

        if (error_count == 0)
            $display("complementary_tilt_filter_unit test passed");
        else
            $display("complementary_tilt_filter_unit test failed");
        $finish;
    end

endmodule
